// ----- hdl/lpp_pkg.sv -----
package lpp_pkg;

   localparam logic [7:0] START_MARK   = 8'hFA;
   localparam int         PACKET_LEN   = 22;
   localparam logic [7:0] INDEX_BASE   = 8'hA0;
   localparam logic [8:0] INDEX_OFFSET = 9'd43;
   localparam logic [8:0] INDEX_MOD    = 9'd90;
   localparam int         SAMPLES      = 4;

   // Byte offsets inside a packet.
   localparam logic [4:0] POS_INDEX     = 5'd1;
   localparam logic [4:0] POS_SPEED_LO  = 5'd2;
   localparam logic [4:0] POS_SPEED_HI  = 5'd3;
   localparam logic [4:0] POS_SAMPLE_LO = 5'd4;
   localparam logic [4:0] POS_SAMPLE_HI = 5'd19;
   localparam logic [4:0] POS_LAST      = 5'(PACKET_LEN - 1);

   typedef logic [3:0][7:0] sample_bytes_type;

   typedef struct packed {
      logic [6:0]                      index;
      logic [15:0]                     speed;
      sample_bytes_type [SAMPLES-1:0]  samples;
   } packet_type;

   // Result word layout, highest bit first.
   typedef struct packed {
      logic [6:0]  pad;
      logic [15:0] rotation_speed;
      logic        weak_signal_flag;
      logic        invalid_flag;
      logic [15:0] signal_strength;
      logic [13:0] distance_mm;
      logic [1:0]  sample_slot;
      logic [6:0]  frame_number;
   } result_type;

   // ((raw - 0xA0) mod 256 + 43) mod 90; the sum stays below 299, so three
   // conditional subtractions finish the reduction.
   function automatic logic [6:0] remap_index(input logic [7:0] raw);
      logic [7:0] diff;
      logic [8:0] v;
      diff = raw - INDEX_BASE;
      v = {1'b0, diff} + INDEX_OFFSET;
      if (v >= INDEX_MOD) begin
         v = v - INDEX_MOD;
      end
      if (v >= INDEX_MOD) begin
         v = v - INDEX_MOD;
      end
      if (v >= INDEX_MOD) begin
         v = v - INDEX_MOD;
      end
      return v[6:0];
   endfunction

endpackage

// ----- hdl/lpp_front.sv -----
module lpp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,
   output logic               push,
   output lpp_pkg::packet_type push_data,
   input  logic               queue_full
);
   import lpp_pkg::*;

   logic [4:0]       byte_count_ff, byte_count_in;
   logic [6:0]       index_ff, index_in;
   logic [15:0]      speed_ff, speed_in;
   logic [15:0][7:0] sample_ff, sample_in;
   logic             accept;
   logic [4:0]       rel_pos;

   // Only the closing byte of a packet needs room in the queue.
   assign req_tready = !(byte_count_ff == POS_LAST && queue_full);
   assign accept     = req_tvalid && req_tready;
   assign rel_pos    = byte_count_ff - POS_SAMPLE_LO;

   always_comb begin
      byte_count_in = byte_count_ff;
      index_in      = index_ff;
      speed_in      = speed_ff;
      sample_in     = sample_ff;
      push          = 1'b0;
      if (accept) begin
         if (byte_count_ff == 5'd0) begin
            if (req_tdata == START_MARK) begin
               byte_count_in = 5'd1;
            end
         end else if (byte_count_ff == POS_LAST) begin
            byte_count_in = 5'd0;
            push          = 1'b1;
         end else begin
            byte_count_in = byte_count_ff + 5'd1;
            if (byte_count_ff == POS_INDEX) begin
               index_in = remap_index(req_tdata);
            end
            if (byte_count_ff == POS_SPEED_LO) begin
               speed_in[7:0] = req_tdata;
            end
            if (byte_count_ff == POS_SPEED_HI) begin
               speed_in[15:8] = req_tdata;
            end
            if (byte_count_ff >= POS_SAMPLE_LO && byte_count_ff <= POS_SAMPLE_HI) begin
               sample_in[rel_pos[3:0]] = req_tdata;
            end
         end
      end
   end

   assign push_data.index   = index_ff;
   assign push_data.speed   = speed_ff;
   assign push_data.samples = sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= 5'd0;
      end else begin
         byte_count_ff <= byte_count_in;
      end
      index_ff  <= index_in;
      speed_ff  <= speed_in;
      sample_ff <= sample_in;
   end

endmodule

// ----- hdl/lpp_queue.sv -----
module lpp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lpp_pkg::packet_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output lpp_pkg::packet_type pop_data
);
   import lpp_pkg::*;

   packet_type  entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign full      = count_ff == 2'd2;
   assign not_empty = count_ff != 2'd0;
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset) !(push && full && !pop))
      else $error("packet queue overflow");
   assert property (@(posedge clock) disable iff (reset) !(pop && !not_empty))
      else $error("packet queue underflow");
   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 2'd1)
      else $error("packet queue count did not follow a push");

endmodule

// ----- hdl/lpp_back.sv -----
module lpp_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               queue_not_empty,
   input  lpp_pkg::packet_type queue_data,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [63:0]        rsp_tdata,
   output logic               rsp_tlast
);
   import lpp_pkg::*;

   packet_type  packet_ff, packet_in;
   logic        active_ff, active_in;
   logic [1:0]  slot_ff, slot_in;
   logic        valid_ff, valid_in;
   result_type  data_ff, data_in;
   logic        last_ff, last_in;
   logic        advance;
   logic [15:0] dist_word;

   assign advance   = !valid_ff || rsp_tready;
   assign pop       = queue_not_empty && (!active_ff || (advance && slot_ff == 2'd3));
   assign dist_word = {packet_ff.samples[slot_ff][1], packet_ff.samples[slot_ff][0]};

   always_comb begin
      packet_in = packet_ff;
      active_in = active_ff;
      slot_in   = slot_ff;
      valid_in  = valid_ff;
      data_in   = data_ff;
      last_in   = last_ff;
      if (advance) begin
         valid_in = active_ff;
         if (active_ff) begin
            data_in.pad              = '0;
            data_in.frame_number     = packet_ff.index;
            data_in.sample_slot      = slot_ff;
            data_in.distance_mm      = dist_word[13:0];
            data_in.signal_strength  = {packet_ff.samples[slot_ff][3],
                                        packet_ff.samples[slot_ff][2]};
            data_in.invalid_flag     = dist_word[15];
            data_in.weak_signal_flag = dist_word[14];
            data_in.rotation_speed   = packet_ff.speed;
            last_in                  = slot_ff == 2'd3;
            slot_in                  = slot_ff + 2'd1;
            if (slot_ff == 2'd3) begin
               active_in = 1'b0;
            end
         end
      end
      if (pop) begin
         packet_in = queue_data;
         active_in = 1'b1;
         slot_in   = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         slot_ff   <= 2'd0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         slot_ff   <= slot_in;
         valid_ff  <= valid_in;
      end
      packet_ff <= packet_in;
      data_ff   <= data_in;
      last_ff   <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tlast == (data_ff.sample_slot == 2'd3))
      else $error("last marker not on the fourth sample");
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && data_ff.sample_slot == $past(data_ff.sample_slot) + 2'd1)
      else $error("sample sequence broken inside a packet");
   assert property (@(posedge clock) disable iff (reset) !active_ff |-> slot_ff == 2'd0)
      else $error("sample slot not cleared while idle");

endmodule

// ----- hdl/lidar_packet_parser_top.sv -----
// Frames 22-byte lidar packets from a byte stream and emits four result words
// per packet, one per distance sample. A packet opens on 0xFA; bytes outside a
// packet that are not 0xFA are dropped. One byte is accepted every cycle while
// req_tready is high; the front decodes fields as bytes arrive and hands a
// finished packet to a two-entry queue, and the back drains it as four words,
// one per cycle while the result side does not stall, with tlast on the
// fourth. req_tready drops only when the closing byte of a packet meets a full
// queue, which takes a stalled result side.
module lidar_packet_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // frame_number[6:0], sample_slot[8:7], distance_mm[22:9],
   // signal_strength[38:23], invalid_flag[39], weak_signal_flag[40],
   // rotation_speed[56:41], zeros above
   output logic [63:0] rsp_tdata,
   output logic        rsp_tlast    // last_sample
);
   import lpp_pkg::*;

   logic       push;
   packet_type push_data;
   logic       queue_full;
   logic       pop;
   logic       queue_not_empty;
   packet_type pop_data;

   lpp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push       (push),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   lpp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .pop_data  (pop_data)
   );

   lpp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_not_empty (queue_not_empty),
      .queue_data      (pop_data),
      .pop             (pop),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast)
   );

endmodule

// ----- verif/lidar_sample_checker.sv -----
module lidar_sample_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,
   input  logic        rsp_tlast,
   output int          error_count,
   output int          samples_pending
);
   import lpp_pkg::*;

   typedef struct {
      logic [6:0]  frame_number;
      logic [1:0]  sample_slot;
      logic [13:0] distance_mm;
      logic [15:0] signal_strength;
      logic        invalid_flag;
      logic        weak_signal_flag;
      logic [15:0] rotation_speed;
      logic        last_sample;
   } sample_type;

   logic [7:0]  frame_bytes [PACKET_LEN];
   int unsigned frame_fill;
   sample_type  expected_samples [$];
   int          errors;

   function automatic logic [6:0] packet_number(input logic [7:0] raw);
      logic [7:0] rel;
      rel = raw - INDEX_BASE;
      return 7'((int'(rel) + int'(INDEX_OFFSET)) % int'(INDEX_MOD));
   endfunction

   function automatic logic [15:0] le_word(input int pos);
      return {frame_bytes[pos + 1], frame_bytes[pos]};
   endfunction

   // Collects packet bytes; the closing byte turns the packet into four samples.
   task automatic take_byte(input logic [7:0] value);
      sample_type  s;
      logic [15:0] range_word;
      logic [15:0] speed;
      logic [6:0]  number;
      int          k;
      if (frame_fill == 0 && value != START_MARK) begin
         return;
      end
      frame_bytes[frame_fill] = value;
      frame_fill++;
      if (frame_fill < PACKET_LEN) begin
         return;
      end
      frame_fill = 0;
      number = packet_number(frame_bytes[POS_INDEX]);
      speed = le_word(int'(POS_SPEED_LO));
      for (k = 0; k < SAMPLES; k++) begin
         range_word = le_word(int'(POS_SAMPLE_LO) + 4 * k);
         s.frame_number = number;
         s.sample_slot = 2'(k);
         s.distance_mm = range_word[13:0];
         s.signal_strength = le_word(int'(POS_SAMPLE_LO) + 4 * k + 2);
         s.invalid_flag = range_word[15];
         s.weak_signal_flag = range_word[14];
         s.rotation_speed = speed;
         s.last_sample = (k == SAMPLES - 1);
         expected_samples = {expected_samples, s};
      end
   endtask

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   task automatic check_sample(input result_type got, input logic got_last);
      sample_type want;
      if (expected_samples.size() == 0) begin
         $error("result word with nothing expected: %h", got);
         errors++;
         return;
      end
      want = expected_samples.pop_front();
      compare_field("frame_number", want.frame_number, got.frame_number);
      compare_field("sample_slot", want.sample_slot, got.sample_slot);
      compare_field("distance_mm", want.distance_mm, got.distance_mm);
      compare_field("signal_strength", want.signal_strength, got.signal_strength);
      compare_field("invalid_flag", want.invalid_flag, got.invalid_flag);
      compare_field("weak_signal_flag", want.weak_signal_flag, got.weak_signal_flag);
      compare_field("rotation_speed", want.rotation_speed, got.rotation_speed);
      compare_field("last_sample", want.last_sample, got_last);
      compare_field("pad", 0, got.pad);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         frame_fill = 0;
         expected_samples.delete();
      end else begin
         // A result word can never belong to a packet closed at the same edge,
         // so checking before predicting is safe.
         if (rsp_tvalid && rsp_tready) begin
            check_sample(rsp_tdata, rsp_tlast);
         end
         if (req_tvalid && req_tready) begin
            take_byte(req_tdata);
         end
      end
      error_count <= errors;
      samples_pending <= expected_samples.size();
   end

endmodule

// ----- verif/lidar_packet_parser_top_test.sv -----
module lidar_packet_parser_top_test;
   import lpp_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        rsp_tlast;
   int          error_count;
   int          samples_pending;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   lidar_packet_parser_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   lidar_sample_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .error_count     (error_count),
      .samples_pending (samples_pending)
   );

   // Mostly back to back or short gaps, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(6, 24);
   endfunction

   function automatic logic [7:0] payload_byte();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         return 8'h00;
      end else if (r < 20) begin
         return 8'hFF;
      end else if (r < 25) begin
         return START_MARK;
      end
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_byte(input logic [7:0] value, input bit hurry);
      int unsigned gap;
      gap = hurry ? 0 : pick_gap();
      if (gap != 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = value;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_frame(input int unsigned count, input bit hurry);
      int unsigned i;
      send_byte(START_MARK, hurry);
      for (i = 1; i < count; i++) begin
         send_byte((i == POS_INDEX) ? 8'($urandom_range(0, 255)) : payload_byte(), hurry);
      end
   endtask

   task automatic wait_for_drain();
      req_tvalid = 1'b0;
      while (samples_pending != 0) @(negedge clock);
   endtask

   // Directed packet: largest index sum, speed and distance extremes, both flags,
   // and stray start marks inside the payload.
   localparam logic [7:0] EDGE_FRAME [PACKET_LEN] = '{
      8'hFA, 8'h9F, 8'hFF, 8'hFF,
      8'hFF, 8'h3F, 8'h00, 8'h00,
      8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'h00, 8'h80, 8'hFA, 8'h00,
      8'h00, 8'h40, 8'h01, 8'hFA,
      8'h00, 8'hFA
   };

   initial begin
      int unsigned sent;
      int unsigned round;
      int unsigned choice;
      int unsigned n;
      int unsigned i;
      logic [7:0]  b;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      // Bytes with no packet open are dropped.
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hF9, 1'b0);
      for (i = 0; i < PACKET_LEN; i++) begin
         send_byte(EDGE_FRAME[i], 1'b0);
      end

      sent = 3 + PACKET_LEN;
      round = 0;
      while (sent < 210) begin
         choice = $urandom_range(0, 99);
         if (round == 4 || choice < 6) begin
            wait_for_drain();
         end
         if (choice < 80) begin
            send_frame(PACKET_LEN, $urandom_range(0, 3) == 0);
            sent += PACKET_LEN;
         end else if (choice < 90) begin
            n = $urandom_range(1, 4);
            repeat (n) begin
               do b = 8'($urandom_range(0, 255)); while (b == START_MARK);
               send_byte(b, 1'b0);
            end
            sent += n;
         end else begin
            // A cut-short packet: the next start mark lands inside it as data.
            n = $urandom_range(1, PACKET_LEN - 1);
            send_frame(n, 1'b0);
            sent += n;
         end
         round++;
      end

      wait_for_drain();
      repeat (16) @(negedge clock);
      if (error_count == 0 && samples_pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Result side: runs of ready, some short and some long, broken by stalls.
   initial begin
      int unsigned run;
      int unsigned idle;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         rsp_tready = 1'b1;
         run = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 60 : 8);
         repeat (run) @(negedge clock);
         idle = pick_gap();
         if (idle != 0) begin
            rsp_tready = 1'b0;
            repeat (idle) @(negedge clock);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
